### hdl/complex_to_polar_top_assert.svh
// Assertion macros shared by the complex-to-polar RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef COMPLEX_TO_POLAR_TOP_ASSERT_SVH
`define COMPLEX_TO_POLAR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define CTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("complex_to_polar assertion failed");
// Next-cycle implication, disabled while reset is low.
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("complex_to_polar assertion failed");
`else
`define CTP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/c2p_pkg.sv
// Shared types and constants for the complex-to-polar CORDIC block.
// Used by c2p_cell, c2p_scale and complex_to_polar_top; no dependencies.
`timescale 1ns / 1ps

package c2p_pkg;

    // Fraction bits added below the input scale in the rotation datapath.
    localparam int GUARD_BITS = 12;

    // 1/K as an unsigned 0.32 fraction.
    localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

    // round(atan(2^-i) / pi * 2^31), i = 0..31.
    localparam logic [31:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Control that travels alongside each word in the pipeline.
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

### hdl/c2p_cell.sv
// One CORDIC vectoring micro-rotation, registered.
// Depends on c2p_pkg for the arctangent table and the control struct.
`timescale 1ns / 1ps

module c2p_cell #(
    parameter int W     = 30,
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  c2p_pkg::t_ctl        i_ctl,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [W-1:0]  i_y,
    input  logic [31:0]          i_z,
    output c2p_pkg::t_ctl        o_ctl,
    output logic signed [W-1:0]  o_x,
    output logic signed [W-1:0]  o_y,
    output logic [31:0]          o_z
);
    import c2p_pkg::*;

    localparam logic [4:0]  IDX   = 5'(SHIFT);
    localparam logic [31:0] ANGLE = ATAN_TABLE[IDX];

    t_ctl               r_ctl;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic [31:0]         r_z;

    logic signed [W-1:0] w_xs;
    logic signed [W-1:0] w_ys;
    logic                w_y_neg;
    logic signed [W-1:0] n_x;
    logic signed [W-1:0] n_y;
    logic [31:0]         n_z;

    assign w_xs    = i_x >>> SHIFT;
    assign w_ys    = i_y >>> SHIFT;
    assign w_y_neg = i_y[W-1];

    // Rotate toward the real axis: direction follows the sign of y.
    always_comb begin
        if (w_y_neg) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### hdl/c2p_scale.sv
// Gain correction, magnitude rounding/saturation and phase rounding.
// Two registered stages; depends on c2p_pkg for the gain and guard bits.
`timescale 1ns / 1ps

module c2p_scale #(
    parameter int DATA_WIDTH = 16,
    parameter int W          = 30
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  c2p_pkg::t_ctl          i_ctl,
    input  logic signed [W-1:0]    i_x,
    input  logic [31:0]            i_z,
    output c2p_pkg::t_ctl          o_ctl,
    output logic [DATA_WIDTH-1:0]  o_magnitude,
    output logic [DATA_WIDTH-1:0]  o_phase_angle
);
    import c2p_pkg::*;

    localparam int XU_W = W - 1;
    localparam int XL_W = (XU_W > 32) ? 32 : XU_W;
    localparam int XH_W = (XU_W > 32) ? XU_W - 32 : 1;
    localparam int R_W  = XU_W + 1;
    localparam int M_W  = R_W - GUARD_BITS;
    localparam logic [R_W-1:0] MAG_HALF = R_W'(1) << (GUARD_BITS - 1);
    localparam logic [31:0]    PH_HALF  =
        (DATA_WIDTH >= 32) ? 32'd0 : (32'd1 << (31 - DATA_WIDTH));

    // x never goes negative after the pre-rotation, so drop its sign bit.
    logic [XU_W-1:0]      w_xu;
    logic [XH_W+XL_W-1:0] w_xext;
    logic [XL_W-1:0]      w_xl;
    logic [XH_W-1:0]      w_xh;

    t_ctl                 r_a_ctl;
    logic [XL_W+31:0]     r_pl;
    logic [XH_W+31:0]     r_ph;
    logic [31:0]          r_a_z;

    logic [R_W-1:0]       w_r;
    logic [M_W-1:0]       w_mag_full;
    logic                 w_sat;
    logic [31:0]          w_ph_sum;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] n_phase;

    t_ctl                  r_b_ctl;
    logic [DATA_WIDTH-1:0] r_mag;
    logic [DATA_WIDTH-1:0] r_phase;

    assign w_xu   = i_x[XU_W-1:0];
    assign w_xext = (XH_W + XL_W)'(w_xu);
    assign w_xl   = w_xext[XL_W-1:0];
    assign w_xh   = w_xext[XH_W+XL_W-1:XL_W];

    // Stage A: split x at bit 32, one partial product per half.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl  <= (XL_W + 32)'(w_xl) * (XL_W + 32)'(GAIN_Q32);
            r_ph  <= (XH_W + 32)'(w_xh) * (XH_W + 32)'(GAIN_Q32);
            r_a_z <= i_z;
        end
    end

    // Stage B: recombine, round half up, saturate; round the angle.
    assign w_r        = R_W'(r_ph) + R_W'(r_pl[XL_W+31:32]) + MAG_HALF;
    assign w_mag_full = w_r[R_W-1:GUARD_BITS];
    assign w_sat      = |w_mag_full[M_W-1:DATA_WIDTH];
    assign w_ph_sum   = r_a_z + PH_HALF;

    always_comb begin
        n_mag   = w_sat ? '1 : w_mag_full[DATA_WIDTH-1:0];
        n_phase = r_a_ctl.zero ? '0 : w_ph_sum[31 -: DATA_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag   <= n_mag;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
        end
    end

    assign o_ctl         = r_b_ctl;
    assign o_magnitude   = r_mag;
    assign o_phase_angle = r_phase;

endmodule

### hdl/complex_to_polar_top.sv
// Usage:
//   Complex sample to polar form by a pipelined CORDIC in vectoring mode.
//   Slave channel (i_s_*) takes one complex word per handshake: real part in
//   the low DATA_WIDTH bits of tdata, imaginary part above it. Master channel
//   (o_m_*) returns one word per input: magnitude low, phase above it, phase
//   in binary angle units where 2^(DATA_WIDTH-1) is pi (+pi reads as -pi).
//   An all-zero input returns magnitude 0 and phase 0.
//   Pipeline: one pre-rotation stage, one cell per micro-rotation, two scaling
//   stages and the output register lie between accept and o_m_tvalid.
//   Throughput: one word per clock while o_s_tready is high, set by the row of
//   rotation cells, each of which hands a word to the next every cycle it advances.
//   A two-entry output register and skid stage let the pipeline keep moving
//   while a result waits; once both hold a word, o_s_tready drops and the
//   whole pipeline holds until the receiver takes one.
//   Reset (i_rst_n low at a clock edge, synchronous) empties the pipeline
//   and the output stage; no word is held across reset.
// Depends on c2p_pkg, c2p_cell, c2p_scale and complex_to_polar_top_assert.svh.
`timescale 1ns / 1ps
`include "complex_to_polar_top_assert.svh"

module complex_to_polar_top #(
    parameter int DATA_WIDTH    = 16,
    parameter int CORDIC_STAGES = 16,
    localparam int TDATA_W      = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // real_part, imag_part, zero pad
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata    // magnitude, phase_angle, zero pad
);
    import c2p_pkg::*;

    localparam int NUM_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int W          = DATA_WIDTH + GUARD_BITS + 2;

    logic w_adv;

    // Pre-rotation into the right half plane.
    logic signed [DATA_WIDTH-1:0] w_re;
    logic signed [DATA_WIDTH-1:0] w_im;
    logic signed [W-1:0]          w_xs;
    logic signed [W-1:0]          w_ys;
    logic                         w_neg;
    t_ctl                         n_pre_ctl;
    logic signed [W-1:0]          n_pre_x;
    logic signed [W-1:0]          n_pre_y;
    logic [31:0]                  n_pre_z;

    t_ctl                w_ctl [NUM_STAGES+1];
    logic signed [W-1:0] w_x   [NUM_STAGES+1];
    logic signed [W-1:0] w_y   [NUM_STAGES+1];
    logic [31:0]         w_z   [NUM_STAGES+1];

    t_ctl                  r_pre_ctl;
    logic signed [W-1:0]   r_pre_x;
    logic signed [W-1:0]   r_pre_y;
    logic [31:0]           r_pre_z;

    t_ctl                  w_p_ctl;
    logic [DATA_WIDTH-1:0] w_p_mag;
    logic [DATA_WIDTH-1:0] w_p_phase;
    logic [TDATA_W-1:0]    w_p_data;
    logic                  w_p_take;

    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_skid_full;
    logic [TDATA_W-1:0] r_skid_data;
    logic               n_out_valid;
    logic [TDATA_W-1:0] n_out_data;
    logic               n_skid_full;
    logic [TDATA_W-1:0] n_skid_data;

    assign w_adv      = !r_skid_full;
    assign o_s_tready = w_adv;

    assign w_re  = i_s_tdata[DATA_WIDTH-1:0];
    assign w_im  = i_s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
    assign w_xs  = W'(w_re) <<< GUARD_BITS;
    assign w_ys  = W'(w_im) <<< GUARD_BITS;
    assign w_neg = w_re[DATA_WIDTH-1];

    // Negative real part: rotate by pi first.
    always_comb begin
        n_pre_ctl.valid = i_s_tvalid;
        n_pre_ctl.zero  = (w_re == '0) && (w_im == '0);
        if (w_neg) begin
            n_pre_x = -w_xs;
            n_pre_y = -w_ys;
            n_pre_z = 32'h8000_0000;
        end else begin
            n_pre_x = w_xs;
            n_pre_y = w_ys;
            n_pre_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctl <= '0;
        end else if (w_adv) begin
            r_pre_ctl <= n_pre_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pre_x <= n_pre_x;
            r_pre_y <= n_pre_y;
            r_pre_z <= n_pre_z;
        end
    end

    assign w_ctl[0] = r_pre_ctl;
    assign w_x[0]   = r_pre_x;
    assign w_y[0]   = r_pre_y;
    assign w_z[0]   = r_pre_z;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
        c2p_cell #(
            .W     (W),
            .SHIFT (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    c2p_scale #(
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_ctl         (w_ctl[NUM_STAGES]),
        .i_x           (w_x[NUM_STAGES]),
        .i_z           (w_z[NUM_STAGES]),
        .o_ctl         (w_p_ctl),
        .o_magnitude   (w_p_mag),
        .o_phase_angle (w_p_phase)
    );

    assign w_p_data = TDATA_W'({w_p_phase, w_p_mag});
    assign w_p_take = w_adv && w_p_ctl.valid;

    // Output register plus skid: park the arriving word when the output stalls.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_skid_full = r_skid_full;
        n_skid_data = r_skid_data;
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_full) begin
                n_out_valid = 1'b1;
                n_out_data  = r_skid_data;
                n_skid_full = 1'b0;
            end else begin
                n_out_valid = w_p_take;
                n_out_data  = w_p_data;
            end
        end else if (w_p_take) begin
            n_skid_full = 1'b1;
            n_skid_data = w_p_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skid_full <= n_skid_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `CTP_ASSERT_SAME(a_skid_needs_out, i_clk, i_rst_n, r_skid_full, r_out_valid)
    `CTP_ASSERT_SAME(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_full), $past(r_out_valid && !i_m_tready))
    `CTP_ASSERT_NEXT(a_pipe_holds, i_clk, i_rst_n, !w_adv, $stable(w_p_ctl.valid) && $stable(w_p_mag) && $stable(w_p_phase))

endmodule

### tb/sv/tb_complex_to_polar_top.sv
// Self-checking testbench for complex_to_polar_top: streams complex words in,
// predicts magnitude and phase with a bit-exact CORDIC model of its own and
// checks every returned word in order. Depends only on the RTL of the block.
`timescale 1ns / 1ps

module tb_complex_to_polar_top;

    localparam int DW          = 16;
    localparam int STAGES      = 16;
    localparam int TDATA_W     = ((2 * DW + 7) / 8) * 8;
    localparam int GUARD       = 12;
    localparam int LATENCY     = STAGES + 4;
    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    localparam longint unsigned GAIN  = 64'h0000_0000_9B74_EDA8;
    localparam longint unsigned WMASK = (64'd1 << DW) - 64'd1;

    // round(atan(2^-i) / pi * 2^31)
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 pinned;   // expected word typed in below
        logic [DW-1:0]        mag;
        logic [DW-1:0]        phase;
    } t_row;

    localparam int NUM_ROWS = 20;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd0, 16'd0},   // zero input
        '{16'sd1,      16'sd0,      1'b0, 16'd0, 16'd0},
        '{16'sd0,      16'sd1,      1'b0, 16'd0, 16'd0},
        '{-16'sd1,     16'sd0,      1'b0, 16'd0, 16'd0},
        '{16'sd0,      -16'sd1,     1'b0, 16'd0, 16'd0},
        '{16'sd1,      16'sd1,      1'b0, 16'd0, 16'd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'd0, 16'd0},
        '{16'sd32767,  16'sd0,      1'b0, 16'd0, 16'd0},
        '{-16'sd32768, 16'sd0,      1'b0, 16'd0, 16'd0},
        '{16'sd0,      16'sd32767,  1'b0, 16'd0, 16'd0},
        '{16'sd0,      -16'sd32768, 1'b0, 16'd0, 16'd0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'd0, 16'd0},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'd0, 16'd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'd0, 16'd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'd0, 16'd0},
        '{-16'sd100,   16'sd0,      1'b0, 16'd0, 16'd0},   // negative real axis
        '{-16'sd32768, 16'sd1,      1'b0, 16'd0, 16'd0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'd0, 16'd0},
        '{16'sd12345,  -16'sd6789,  1'b0, 16'd0, 16'd0},
        '{-16'sd20000, 16'sd15000,  1'b0, 16'd0, 16'd0}
    };

    localparam logic signed [DW-1:0] EDGE_VALS [6] = '{
        -16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
    };

    logic               i_clk;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata  = '0;   // real_part, imag_part
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;         // magnitude, phase_angle

    logic [2*DW-1:0] polar_q [$];   // {phase, magnitude} words still owed
    int              mismatch_count = 0;
    int              burst_left     = 0;
    bit              hold_request   = 1'b0;

    complex_to_polar_top #(
        .DATA_WIDTH   (DW),
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Vectoring CORDIC on a 64-bit datapath; returns {phase, magnitude}.
    function automatic logic [2*DW-1:0] polar_of(input logic signed [DW-1:0] re,
                                                 input logic signed [DW-1:0] im);
        longint          x, y, nx, ny;
        logic [31:0]     z;
        longint unsigned xu, r, mag, ph;
        int              n;
        if (re == 0 && im == 0) begin
            return '0;
        end
        x = longint'(re) <<< GUARD;
        y = longint'(im) <<< GUARD;
        z = 32'd0;
        // fold the left half plane over by pi
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        n = (STAGES > 32) ? 32 : STAGES;
        for (int i = 0; i < n; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        xu  = (x < 0) ? 64'd0 : unsigned'(x);
        r   = (xu >> 32) * GAIN + (((xu & 64'hFFFF_FFFF) * GAIN) >> 32);
        mag = (r + (64'd1 << (GUARD - 1))) >> GUARD;
        if (mag > WMASK) begin
            mag = WMASK;
        end
        if (DW >= 32) begin
            ph = {32'd0, z};
        end else begin
            ph = ({32'd0, z} + (64'd1 << (31 - DW))) >> (32 - DW);
        end
        return {ph[DW-1:0], mag[DW-1:0]};
    endfunction

    // Open a new burst, with a random gap (possibly none) in front of it, once the current one runs out.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer_sample(input logic signed [DW-1:0] re,
                                input logic signed [DW-1:0] im,
                                input logic [2*DW-1:0] want);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'({im, re});
        do @(posedge i_clk); while (!o_s_tready);
        polar_q.insert(polar_q.size(), want);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (polar_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_sample(output logic signed [DW-1:0] re,
                               output logic signed [DW-1:0] im);
        logic signed [DW-1:0] v;
        v = DW'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                re = DW'($urandom);
                im = DW'($urandom);
            end
            4, 5: begin
                re = DW'($urandom_range(0, 511) - 256);
                im = DW'($urandom_range(0, 511) - 256);
            end
            6: begin
                re = $urandom_range(0, 1) ? v : '0;
                im = (re == 0) ? v : '0;
            end
            7: begin
                re = EDGE_VALS[$urandom_range(0, 5)];
                im = EDGE_VALS[$urandom_range(0, 5)];
            end
            8: begin
                re = v;
                im = $urandom_range(0, 1) ? v : -v;
            end
            default: begin
                // near the negative real axis
                re = DW'(-$urandom_range(1, 32768));
                im = DW'($urandom_range(0, 4) - 2);
            end
        endcase
    endtask

    // Receiver: stall pattern in segments, plus one long hold-off on request.
    initial begin
        int mode;
        int seg;
        logic rdy;
        wait (i_rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            for (int c = 0; c < seg; c++) begin
                if (hold_request) begin
                    i_m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (c % 4) == 3;
                    default: rdy = $urandom_range(0, 7) == 0;
                endcase
                i_m_tready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    // Compare every returned word with the oldest owed one.
    initial begin
        logic [2*DW-1:0] want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (polar_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result word %h", o_m_tdata);
                    end
                end else begin
                    want = polar_q.pop_front();
                    if (o_m_tdata[DW-1:0] !== want[DW-1:0] ||
                        o_m_tdata[2*DW-1:DW] !== want[2*DW-1:DW]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: magnitude exp %0d got %0d, phase exp %0d got %0d",
                                     want[DW-1:0], o_m_tdata[DW-1:0],
                                     $signed(want[2*DW-1:DW]),
                                     $signed(o_m_tdata[2*DW-1:DW]));
                        end
                    end
                end
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            pace_sender();
            offer_sample(DIRECTED[k].re, DIRECTED[k].im,
                         DIRECTED[k].pinned ? {DIRECTED[k].phase, DIRECTED[k].mag}
                                            : polar_of(DIRECTED[k].re, DIRECTED[k].im));
        end
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) begin
                // hold the receiver off and keep pushing back-to-back
                hold_request = 1'b1;
                burst_left   = 80;
            end
            if (n == 800) begin
                drain_results();
            end
            pace_sender();
            pick_sample(re, im);
            offer_sample(re, im, polar_of(re, im));
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && polar_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
